// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the two-class priority queue
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define TPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tpq assertion failed");

// checked at every edge, reset included
`define TPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tpq assertion failed");

`else

`define TPQ_ASSERT(lbl, clk, rstn, prop)
`define TPQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/tpq_pkg.sv =====
// package of the two-class priority queue: item types, codes and defaults
// no dependencies
package tpq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagWidthDef   = 32;
  localparam int unsigned TurnWidthDef  = 16;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned InTagW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OutTurnW = 16;
  localparam int unsigned OutTagW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_HIGH   = 2'd0,
    MODE_PUSH_NORMAL = 2'd1,
    MODE_SERVE       = 2'd2,
    MODE_SERVE_ALT   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED      = 3'd0,
    ST_DROPPED       = 3'd1,
    ST_SERVED_HIGH   = 3'd2,
    ST_SERVED_NORMAL = 3'd3,
    ST_NONE          = 3'd4
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [InTagW-1:0] client_tag;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [OutTurnW-1:0] turn_number;
    logic [OutTagW-1:0]  served_tag;
  } out_item_t;

  // request from the top level to one class chain
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctrl_t;

  // occupancy reported by one class chain
  typedef struct packed {
    logic empty;
    logic full;
  } chain_status_t;

endpackage

// ===== src/tpq_cell.sv =====
// one storage cell of a class chain: holds a {turn, tag} entry
// loads a new entry or takes its right-hand neighbour's on a serve
module tpq_cell #(
  parameter int unsigned TAG_WIDTH  = tpq_pkg::TagWidthDef,
  parameter int unsigned TURN_WIDTH = tpq_pkg::TurnWidthDef
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  shift_i,
  input  logic [TURN_WIDTH-1:0] new_turn_i,
  input  logic [TAG_WIDTH-1:0]  new_tag_i,
  input  logic [TURN_WIDTH-1:0] nbr_turn_i,
  input  logic [TAG_WIDTH-1:0]  nbr_tag_i,
  output logic [TURN_WIDTH-1:0] turn_o,
  output logic [TAG_WIDTH-1:0]  tag_o
);

  logic [TURN_WIDTH-1:0] turn_q, turn_d;
  logic [TAG_WIDTH-1:0]  tag_q, tag_d;

  always_comb begin
    turn_d = turn_q;
    tag_d  = tag_q;
    if (shift_i) begin
      turn_d = nbr_turn_i;
      tag_d  = nbr_tag_i;
    end else if (load_i) begin
      turn_d = new_turn_i;
      tag_d  = new_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    turn_q <= turn_d;
    tag_q  <= tag_d;
  end

  assign turn_o = turn_q;
  assign tag_o  = tag_q;

endmodule

// ===== src/tpq_chain.sv =====
// one priority class: a row of tpq_cell with the oldest entry in cell 0
// holds the fill count and the class turn counter; uses tpq_pkg
module tpq_chain #(
  parameter int unsigned QUEUE_DEPTH = tpq_pkg::QueueDepthDef,
  parameter int unsigned TAG_WIDTH   = tpq_pkg::TagWidthDef,
  parameter int unsigned TURN_WIDTH  = tpq_pkg::TurnWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpq_pkg::chain_ctrl_t    ctrl_i,
  input  logic [TAG_WIDTH-1:0]    tag_i,
  output tpq_pkg::chain_status_t  status_o,
  output logic [TURN_WIDTH-1:0]   next_turn_o,
  output logic [TURN_WIDTH-1:0]   head_turn_o,
  output logic [TAG_WIDTH-1:0]    head_tag_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]       count_q, count_d;
  logic [TURN_WIDTH-1:0] turn_q, turn_d;
  logic                  full, empty, do_push, do_pop;

  logic [TURN_WIDTH-1:0] cell_turn [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0]  cell_tag  [QUEUE_DEPTH];

  assign full    = (count_q == CntW'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = ctrl_i.push && !full;
  assign do_pop  = ctrl_i.pop && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TURN_WIDTH-1:0] nbr_turn;
    logic [TAG_WIDTH-1:0]  nbr_tag;

    // the last cell has no neighbour; its entry is vacated on a serve
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_turn = '0;
      assign nbr_tag  = '0;
    end else begin : g_mid
      assign nbr_turn = cell_turn[i+1];
      assign nbr_tag  = cell_tag[i+1];
    end

    tpq_cell #(
      .TAG_WIDTH  (TAG_WIDTH),
      .TURN_WIDTH (TURN_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .load_i     (do_push && (count_q == CntW'(i))),
      .shift_i    (do_pop),
      .new_turn_i (turn_q),
      .new_tag_i  (tag_i),
      .nbr_turn_i (nbr_turn),
      .nbr_tag_i  (nbr_tag),
      .turn_o     (cell_turn[i]),
      .tag_o      (cell_tag[i])
    );
  end

  always_comb begin
    count_d = count_q;
    turn_d  = turn_q;
    // the turn is consumed even when the entry is dropped
    if (ctrl_i.push) begin
      turn_d = turn_q + TURN_WIDTH'(1);
    end
    if (do_push) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      turn_q  <= TURN_WIDTH'(1);
    end else begin
      count_q <= count_d;
      turn_q  <= turn_d;
    end
  end

  assign status_o.empty = empty;
  assign status_o.full  = full;
  assign next_turn_o    = turn_q;
  assign head_turn_o    = cell_turn[0];
  assign head_tag_o     = cell_tag[0];

endmodule

// ===== src/two_class_priority_queue_top.sv =====
// Two-class strict-priority queue.
// Input channel (in_valid_i, in_stall_o, in_item_i): mode 0 enqueues
// client_tag in the high class, mode 1 in the normal class, modes 2 and 3
// serve the oldest high entry, else the oldest normal entry.
// Output channel (out_valid_o, out_stall_i, out_item_o): one result item per
// request with status, turn number and served tag.
// The result is registered in the output register on acceptance.
// Throughput: one item per cycle while out_stall_i does not hold a waiting
// result; the addressed chain loads one cell or shifts all its cells in the
// accepting cycle and cell 0 always holds the head, so no request waits on another.
// Each class holds QUEUE_DEPTH entries; an enqueue to a full class is
// dropped with status dropped, its turn still consumed.
// Reset clears both fill counts and sets both turn counters to one; there is
// no clearing pass, the block accepts items as soon as reset is released.
// While out_stall_i holds a waiting result, in_stall_o is high and the
// result stays unchanged.
// Depends on tpq_pkg, tpq_chain, tpq_cell and assert_macros.svh.
`include "assert_macros.svh"

module two_class_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = tpq_pkg::QueueDepthDef,
  parameter int unsigned TAG_WIDTH   = tpq_pkg::TagWidthDef,
  parameter int unsigned TURN_WIDTH  = tpq_pkg::TurnWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpq_pkg::out_item_t out_item_o
);

  logic                   in_acc, serve;
  logic [TAG_WIDTH-1:0]   tag_in;
  tpq_pkg::chain_ctrl_t   hi_ctrl, no_ctrl;
  tpq_pkg::chain_status_t hi_st, no_st;
  logic [TURN_WIDTH-1:0]  hi_next, no_next, hi_turn, no_turn;
  logic [TAG_WIDTH-1:0]   hi_tag, no_tag;
  logic [TURN_WIDTH-1:0]  res_turn;
  logic [TAG_WIDTH-1:0]   res_tag;
  tpq_pkg::status_e       res_status;
  tpq_pkg::out_item_t     out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  // serve is decoded by the high mode bit
  assign serve      = in_item_i.mode[1];

  // keep the low tag bits, zero-extend where storage is wider
  always_comb begin
    tag_in = '0;
    for (int b = 0; b < TAG_WIDTH && b < tpq_pkg::InTagW; b++) begin
      tag_in[b] = in_item_i.client_tag[b];
    end
  end

  always_comb begin
    hi_ctrl.push = in_acc && (in_item_i.mode == tpq_pkg::MODE_PUSH_HIGH);
    no_ctrl.push = in_acc && (in_item_i.mode == tpq_pkg::MODE_PUSH_NORMAL);
    hi_ctrl.pop  = in_acc && serve && !hi_st.empty;
    no_ctrl.pop  = in_acc && serve && hi_st.empty && !no_st.empty;
  end

  tpq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH),
    .TURN_WIDTH  (TURN_WIDTH)
  ) u_high (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (hi_ctrl),
    .tag_i       (tag_in),
    .status_o    (hi_st),
    .next_turn_o (hi_next),
    .head_turn_o (hi_turn),
    .head_tag_o  (hi_tag)
  );

  tpq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH),
    .TURN_WIDTH  (TURN_WIDTH)
  ) u_normal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (no_ctrl),
    .tag_i       (tag_in),
    .status_o    (no_st),
    .next_turn_o (no_next),
    .head_turn_o (no_turn),
    .head_tag_o  (no_tag)
  );

  always_comb begin
    res_turn   = '0;
    res_tag    = '0;
    res_status = tpq_pkg::ST_NONE;
    case (in_item_i.mode)
      tpq_pkg::MODE_PUSH_HIGH: begin
        res_turn   = hi_next;
        res_status = hi_st.full ? tpq_pkg::ST_DROPPED : tpq_pkg::ST_ENQUEUED;
      end
      tpq_pkg::MODE_PUSH_NORMAL: begin
        res_turn   = no_next;
        res_status = no_st.full ? tpq_pkg::ST_DROPPED : tpq_pkg::ST_ENQUEUED;
      end
      default: begin
        if (!hi_st.empty) begin
          res_turn   = hi_turn;
          res_tag    = hi_tag;
          res_status = tpq_pkg::ST_SERVED_HIGH;
        end else if (!no_st.empty) begin
          res_turn   = no_turn;
          res_tag    = no_tag;
          res_status = tpq_pkg::ST_SERVED_NORMAL;
        end
      end
    endcase
  end

  // fit stored turn and tag to the fixed output field widths
  always_comb begin
    out_d = '0;
    out_d.status = res_status;
    for (int b = 0; b < TURN_WIDTH && b < tpq_pkg::OutTurnW; b++) begin
      out_d.turn_number[b] = res_turn[b];
    end
    for (int b = 0; b < TAG_WIDTH && b < tpq_pkg::OutTagW; b++) begin
      out_d.served_tag[b] = res_tag[b];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TPQ_ASSERT(a_result_follows, clk_i, rst_ni, in_acc |=> out_valid_o)
  `TPQ_ASSERT(a_high_first, clk_i, rst_ni,
              in_acc && serve && !hi_st.empty |=>
              out_item_o.status == tpq_pkg::ST_SERVED_HIGH)
  `TPQ_ASSERT(a_full_drops, clk_i, rst_ni,
              hi_ctrl.push && hi_st.full |=>
              out_item_o.status == tpq_pkg::ST_DROPPED)
  `TPQ_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o)

endmodule

// ===== dv/two_class_priority_queue_top_tb.sv =====
// testbench for two_class_priority_queue_top: directed and random request items
// checked against an in-bench model of both class queues; depends on tpq_pkg
// and the rtl under src
module two_class_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    logic [tpq_pkg::OutTurnW-1:0]    turn;
    logic [tpq_pkg::TagWidthDef-1:0] tag;
  } ticket_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tpq_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tpq_pkg::out_item_t out_item_o;

  // model of the two class queues
  ticket_t                      high_line[$];
  ticket_t                      normal_line[$];
  logic [tpq_pkg::OutTurnW-1:0] high_next = 16'd1;
  logic [tpq_pkg::OutTurnW-1:0] normal_next = 16'd1;

  tpq_pkg::out_item_t pending_results[$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  int                 tx_max_gap = 10;
  int                 rx_max_gap = 10;
  int                 stall_left = 0;
  bit                 result_taken = 1'b0;

  two_class_priority_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic tpq_pkg::out_item_t predict_queue_result(tpq_pkg::in_item_t req);
    tpq_pkg::out_item_t           res;
    ticket_t                      tk;
    logic [tpq_pkg::OutTurnW-1:0] turn;
    logic                         to_normal;
    int                           fill;
    res = '0;
    // high bit of the mode selects a serve, so mode three serves as well
    if (req.mode[1]) begin
      if (high_line.size() != 0) begin
        tk = high_line.pop_front();
        res.status = tpq_pkg::ST_SERVED_HIGH;
        res.turn_number = tk.turn;
        res.served_tag = tk.tag;
      end else if (normal_line.size() != 0) begin
        tk = normal_line.pop_front();
        res.status = tpq_pkg::ST_SERVED_NORMAL;
        res.turn_number = tk.turn;
        res.served_tag = tk.tag;
      end else begin
        res.status = tpq_pkg::ST_NONE;
      end
    end else begin
      to_normal = req.mode[0];
      turn = to_normal ? normal_next : high_next;
      // turn is consumed even when the item is dropped
      if (to_normal) normal_next = turn + 1'b1;
      else high_next = turn + 1'b1;
      res.turn_number = turn;
      fill = to_normal ? normal_line.size() : high_line.size();
      if (fill >= tpq_pkg::QueueDepthDef) begin
        res.status = tpq_pkg::ST_DROPPED;
      end else begin
        tk.turn = turn;
        tk.tag = req.client_tag[tpq_pkg::TagWidthDef-1:0];
        if (to_normal) normal_line.push_back(tk);
        else high_line.push_back(tk);
        res.status = tpq_pkg::ST_ENQUEUED;
      end
    end
    return res;
  endfunction

  // result side: a fresh stall length is drawn once an item has been taken
  always @(negedge clk_i) begin
    if (result_taken) begin
      stall_left = $urandom_range(rx_max_gap, 0);
      result_taken = 1'b0;
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    tpq_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_taken = 1'b1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d turn %0d tag %h",
                   out_item_o.status, out_item_o.turn_number,
                   out_item_o.served_tag);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status ||
            out_item_o.turn_number !== want.turn_number ||
            out_item_o.served_tag !== want.served_tag) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected status %0d turn %0d tag %h,",
                      " got status %0d turn %0d tag %h"},
                     want.status, want.turn_number, want.served_tag,
                     out_item_o.status, out_item_o.turn_number,
                     out_item_o.served_tag);
        end
      end
    end
  end

  task automatic send_request(input tpq_pkg::mode_e req_mode,
                              input logic [tpq_pkg::InTagW-1:0] tag);
    tpq_pkg::in_item_t req;
    int                gap;
    req.mode = req_mode;
    req.client_tag = tag;
    gap = $urandom_range(tx_max_gap, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_queue_result(req));
  endtask

  task automatic wait_for_drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain_queues;
    int n;
    n = high_line.size() + normal_line.size();
    repeat (n) send_request(tpq_pkg::MODE_SERVE, $urandom());
  endtask

  task automatic test_empty_serve;
    send_request(tpq_pkg::MODE_SERVE, 32'hFFFF_FFFF);
    send_request(tpq_pkg::MODE_SERVE_ALT, 32'h0000_0000);
  endtask

  task automatic test_priority_order;
    send_request(tpq_pkg::MODE_PUSH_NORMAL, 32'h0000_0000);
    send_request(tpq_pkg::MODE_PUSH_HIGH, 32'hFFFF_FFFF);
    send_request(tpq_pkg::MODE_PUSH_NORMAL, 32'h5A5A_5A5A);
    // high entry goes first although it came later
    send_request(tpq_pkg::MODE_SERVE_ALT, 32'hA5A5_A5A5);
    send_request(tpq_pkg::MODE_SERVE, 32'h0000_0000);
    send_request(tpq_pkg::MODE_SERVE, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_drop;
    for (int i = 0; i < tpq_pkg::QueueDepthDef; i++)
      send_request(tpq_pkg::MODE_PUSH_HIGH, (32'h1 << (2 * i)) ^ 32'hAAAA_AAAA);
    send_request(tpq_pkg::MODE_PUSH_HIGH, 32'h1234_5678);
  endtask

  task automatic test_back_to_back;
    tx_max_gap = 0;
    rx_max_gap = 0;
    drain_queues();
    // overfill the normal class with no gaps, then stack high entries on top
    repeat (tpq_pkg::QueueDepthDef + 4)
      send_request(tpq_pkg::MODE_PUSH_NORMAL, $urandom());
    repeat (tpq_pkg::QueueDepthDef / 2)
      send_request(tpq_pkg::MODE_PUSH_HIGH, $urandom());
    drain_queues();
    send_request(tpq_pkg::MODE_SERVE, $urandom());
    tx_max_gap = 10;
    rx_max_gap = 10;
  endtask

  task automatic test_random_traffic;
    int          push_pct;
    int          pick;
    logic [31:0] tag;
    for (int phase = 0; phase < 6; phase++) begin
      push_pct = $urandom_range(80, 25);
      tx_max_gap = (phase == 2) ? 0 : 10;
      rx_max_gap = (phase == 2) ? 0 : 10;
      for (int n = 0; n < 300; n++) begin
        pick = $urandom_range(99, 0);
        case ($urandom_range(7, 0))
          0:       tag = '0;
          1:       tag = '1;
          default: tag = $urandom();
        endcase
        if (pick < push_pct)
          send_request($urandom_range(1, 0) ? tpq_pkg::MODE_PUSH_NORMAL
                                            : tpq_pkg::MODE_PUSH_HIGH, tag);
        else
          send_request($urandom_range(1, 0) ? tpq_pkg::MODE_SERVE_ALT
                                            : tpq_pkg::MODE_SERVE, tag);
      end
      if (phase % 2 == 1) wait_for_drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_serve();
    test_priority_order();
    test_full_drop();
    wait_for_drain();
    test_back_to_back();
    test_random_traffic();
    wait_for_drain();
    // keep the clock running to catch any stray item
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== two_class_priority_queue_top.f =====
+incdir+src
src/tpq_pkg.sv
src/tpq_cell.sv
src/tpq_chain.sv
src/two_class_priority_queue_top.sv
dv/two_class_priority_queue_top_tb.sv
